FILE: sv/multilevel_feedback_scheduler_defines.svh
// Assertion macros for the scheduler RTL.
// Depends on a clk and an active-low rst_n in the including module.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mfs_pkg.sv
// Types, codes and defaults for the multilevel feedback scheduler.
// No dependencies; imported by every scheduler module but mfs_ram.
package mfs_pkg;

    localparam int LAST_LEVEL_DEF  = 3;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int CMD_DEPTH       = 2;
    localparam int EL_BITS_W       = 5;

    localparam logic [1:0] KIND_ARRIVE  = 2'd0;
    localparam logic [1:0] KIND_PREEMPT = 2'd1;
    localparam logic [1:0] KIND_SELECT  = 2'd2;
    localparam logic [1:0] KIND_CHECK   = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  proc_id;
        logic [15:0] service_time;
        logic [15:0] done_time;
        logic [15:0] elapsed_time;
    } item_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  out_id;
        logic [15:0] out_service;
        logic [15:0] out_done;
        logic [1:0]  level;
        logic        keep_running;
        logic        none_waiting;
        logic        rejected;
    } result_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] service;
        logic [15:0] done;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic [1:0]           kind;
        rec_t                 rec;
        logic                 finish;
        logic [EL_BITS_W-1:0] el_bits;
    } cmd_t;

endpackage

FILE: sv/multilevel_feedback_scheduler.sv
// Multilevel feedback scheduler: an arrival, preemption or continue check
// taken from the head of the two-entry command queue goes straight into the
// result register, a select first through the registered read of the record
// store; the input side keeps taking beats into the command queue while a
// result waits to be popped, until the command queue is full.
// Top level; depends on mfs_pkg, mfs_front, mfs_cmd_queue and mfs_back.
module multilevel_feedback_scheduler
    import mfs_pkg::*;
#(
    parameter int LAST_LEVEL  = LAST_LEVEL_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    cmd_t front_cmd, q_cmd;
    logic q_valid, q_pop;

    mfs_front u_front (
        .item (item),
        .cmd  (front_cmd)
    );

    mfs_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (full),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop)
    );

    mfs_back #(
        .LAST_LEVEL  (LAST_LEVEL),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

FILE: sv/mfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/mfs_front.sv
// Front end: decodes an incoming beat into a scheduler command.
// Depends on mfs_pkg.
module mfs_front
    import mfs_pkg::*;
(
    input  item_t item,
    output cmd_t  cmd
);

    logic [16:0]          sum;
    logic [EL_BITS_W-1:0] el_bits;

    always_comb
    begin
        el_bits = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (item.elapsed_time[i])
            begin
                el_bits = EL_BITS_W'(i + 1);
            end
        end
    end

    assign sum = {1'b0, item.done_time} + {1'b0, item.elapsed_time};

    assign cmd.kind        = item.kind;
    assign cmd.rec.id      = item.proc_id;
    assign cmd.rec.service = item.service_time;
    assign cmd.rec.done    = item.done_time;
    assign cmd.finish      = (sum == {1'b0, item.service_time});
    assign cmd.el_bits     = el_bits;

endmodule

FILE: sv/mfs_cmd_queue.sv
// Short command queue between the front end and the back end.
// Depends on mfs_pkg.
module mfs_cmd_queue
    import mfs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic cmd_valid,
    output cmd_t cmd,
    input  logic cmd_pop
);

    localparam int IW = $clog2(CMD_DEPTH);
    localparam int CW = $clog2(CMD_DEPTH + 1);

    cmd_t          slot_reg [CMD_DEPTH];
    logic [IW-1:0] wr_reg, wr_next;
    logic [IW-1:0] rd_reg, rd_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == CW'(CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = slot_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == IW'(CMD_DEPTH - 1)) ? '0 : wr_reg + IW'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == IW'(CMD_DEPTH - 1)) ? '0 : rd_reg + IW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

FILE: sv/mfs_back.sv
// Back end: ready queues, record store, selection and result register.
// Depends on mfs_pkg, mfs_ram and the scheduler assertion macros.
`include "multilevel_feedback_scheduler_defines.svh"
module mfs_back
    import mfs_pkg::*;
#(
    parameter int LAST_LEVEL  = LAST_LEVEL_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output result_t result,
    output logic    empty,
    input  logic    pop
);

    localparam int NUM_LEVELS = LAST_LEVEL + 1;
    localparam int LW         = $clog2(NUM_LEVELS);
    localparam int PW         = $clog2(QUEUE_DEPTH);
    localparam int FW         = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS      = NUM_LEVELS * QUEUE_DEPTH;
    localparam int AW         = $clog2(SLOTS);
    localparam int TW         = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic [PW-1:0] head_reg [NUM_LEVELS];
    logic [PW-1:0] head_next [NUM_LEVELS];
    logic [PW-1:0] tail_reg [NUM_LEVELS];
    logic [PW-1:0] tail_next [NUM_LEVELS];
    logic [FW-1:0] fill_reg [NUM_LEVELS];
    logic [FW-1:0] fill_next [NUM_LEVELS];
    logic [LW-1:0] running_reg, running_next;
    logic [TW-1:0] total_reg, total_next;
    logic [TW-1:0] fill_sum;
    result_t       res_reg, res_next;
    logic          res_valid_reg, res_valid_next;

    logic          take, is_ins, is_sel, ins_full, sel_found, ram_we, ram_re;
    logic [LW-1:0] ins_lvl, sel_lvl;
    logic [AW-1:0] waddr, raddr;
    logic [REC_W-1:0] rdata;
    rec_t          rd_rec;

    always_comb
    begin
        sel_found = 1'b0;
        sel_lvl   = '0;
        fill_sum  = '0;
        for (int i = LAST_LEVEL; i >= 0; i--)
        begin
            fill_sum = fill_sum + TW'(fill_reg[i]);
            if (fill_reg[i] != '0)
            begin
                sel_found = 1'b1;
                sel_lvl   = LW'(i);
            end
        end
    end

    always_comb
    begin
        is_ins  = 1'b0;
        is_sel  = 1'b0;
        ins_lvl = '0;
        unique case (cmd.kind)
            KIND_ARRIVE:
            begin
                is_ins = 1'b1;
            end
            KIND_PREEMPT:
            begin
                is_ins  = 1'b1;
                ins_lvl = (running_reg == LW'(LAST_LEVEL)) ? running_reg
                                                           : running_reg + LW'(1);
            end
            KIND_SELECT:
            begin
                is_sel = 1'b1;
            end
            default:
            begin
                is_ins = 1'b0;
            end
        endcase
    end

    assign ins_full = (fill_reg[ins_lvl] == FW'(QUEUE_DEPTH));
    assign take     = (state_reg == ST_IDLE) && cmd_valid && (!res_valid_reg || pop);
    assign cmd_pop  = take;
    assign ram_we   = take && is_ins && !ins_full;
    assign ram_re   = take && is_sel && sel_found;
    assign waddr    = AW'(ins_lvl) * AW'(QUEUE_DEPTH) + AW'(tail_reg[ins_lvl]);
    assign raddr    = AW'(sel_lvl) * AW'(QUEUE_DEPTH) + AW'(head_reg[sel_lvl]);
    assign rd_rec   = rec_t'(rdata);

    mfs_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (cmd.rec),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        running_next   = running_reg;
        total_next     = total_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;

        if (ram_we)
        begin
            tail_next[ins_lvl] = (tail_reg[ins_lvl] == PW'(QUEUE_DEPTH - 1)) ? '0
                               : tail_reg[ins_lvl] + PW'(1);
            fill_next[ins_lvl] = fill_reg[ins_lvl] + FW'(1);
            total_next         = total_reg + TW'(1);
        end
        if (ram_re)
        begin
            head_next[sel_lvl] = (head_reg[sel_lvl] == PW'(QUEUE_DEPTH - 1)) ? '0
                               : head_reg[sel_lvl] + PW'(1);
            fill_next[sel_lvl] = fill_reg[sel_lvl] - FW'(1);
            total_next         = total_reg - TW'(1);
            running_next       = sel_lvl;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    res_next              = '0;
                    res_next.none_waiting = (total_next == '0);
                    res_next.rejected     = is_ins && ins_full;
                    if (cmd.kind == KIND_CHECK)
                    begin
                        res_next.keep_running = !cmd.finish
                            && ((running_reg == LW'(LAST_LEVEL))
                                || (cmd.el_bits <= EL_BITS_W'(running_reg)));
                    end
                    if (ram_re)
                    begin
                        res_next.found = 1'b1;
                        res_next.level = 2'(sel_lvl);
                        state_next     = ST_READ;
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                res_next.out_id      = rd_rec.id;
                res_next.out_service = rd_rec.service;
                res_next.out_done    = rd_rec.done;
                res_valid_next       = 1'b1;
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            running_reg   <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result = res_reg;
    assign empty  = !res_valid_reg;

    `MFS_ASSERT_NOW(a_total_tracks_fill, 1'b1, fill_sum == total_reg, "waiting count off")
    `MFS_ASSERT_NEXT(a_read_one_cycle, state_reg == ST_READ, state_reg == ST_IDLE, "read stuck")
    `MFS_ASSERT_NOW(a_read_slot_free, state_reg == ST_READ, !res_valid_reg, "result overrun")
    `MFS_ASSERT_NOW(a_select_not_empty, ram_re, total_reg != '0, "select on empty queues")

endmodule
